// ----- rtl/core/gmt_pkg.sv -----
// package: sizes, command and status codes for the group membership table
package gmt_pkg;

    localparam int GROUP_SLOTS       = 16;
    localparam int MEMBERS_PER_GROUP = 16;
    localparam int SLOT_W  = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
    localparam int MEM_W   = (MEMBERS_PER_GROUP > 1) ? $clog2(MEMBERS_PER_GROUP) : 1;
    localparam int COUNT_W = $clog2(MEMBERS_PER_GROUP + 1);
    localparam int DEPTH   = GROUP_SLOTS * MEMBERS_PER_GROUP;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] CMD_ADD_GROUP  = 3'd0;
    localparam logic [2:0] CMD_DEL_GROUP  = 3'd1;
    localparam logic [2:0] CMD_ADD_MEMBER = 3'd2;
    localparam logic [2:0] CMD_DEL_MEMBER = 3'd3;
    localparam logic [2:0] CMD_QUERY      = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GSCAN,
        S_MREAD,
        S_MSCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    // what the slot chain tells the sequencer after a full pass
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] found_slot;
        logic              free;
        logic [SLOT_W-1:0] free_slot;
    } scan_res_t;

endpackage

// ----- rtl/core/gmt_slot_cell.sv -----
// one cell of the slot chain: holds a group identifier and passes the scan token
module gmt_slot_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [gmt_pkg::SLOT_W-1:0] my_slot,
    input  logic                       write_en,
    input  logic                       clear_en,
    input  logic [31:0]                write_gid,
    input  logic [31:0]                key,
    input  logic                       tok_in,
    input  logic                       fnd_in,
    input  logic [gmt_pkg::SLOT_W-1:0] fnd_slot_in,
    input  logic                       fre_in,
    input  logic [gmt_pkg::SLOT_W-1:0] fre_slot_in,
    output logic                       tok_out,
    output logic                       fnd_out,
    output logic [gmt_pkg::SLOT_W-1:0] fnd_slot_out,
    output logic                       fre_out,
    output logic [gmt_pkg::SLOT_W-1:0] fre_slot_out
);

    logic        valid_reg;
    logic [31:0] gid_reg;
    logic        hit;

    assign hit = valid_reg && (gid_reg == key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_out   <= 1'b0;
            fnd_out   <= 1'b0;
            fre_out   <= 1'b0;
        end
        else
        begin
            if (write_en)
                valid_reg <= 1'b1;
            else if (clear_en)
                valid_reg <= 1'b0;
            tok_out <= tok_in;
            if (tok_in)
            begin
                fnd_out <= fnd_in || hit;
                fre_out <= fre_in || !valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
            gid_reg <= write_gid;
        if (tok_in)
        begin
            fnd_slot_out <= (!fnd_in && hit) ? my_slot : fnd_slot_in;
            fre_slot_out <= (!fre_in && !valid_reg) ? my_slot : fre_slot_in;
        end
    end

endmodule

// ----- rtl/core/gmt_slot_chain.sv -----
// chain of slot cells; a token walks the chain and collects match and free slot
module gmt_slot_chain (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [31:0]                key,
    input  logic                       write_en,
    input  logic                       clear_en,
    input  logic [gmt_pkg::SLOT_W-1:0] sel_slot,
    output logic                       done,
    output gmt_pkg::scan_res_t         res
);

    localparam int N = gmt_pkg::GROUP_SLOTS;

    logic                       tok [N+1];
    logic                       fnd [N+1];
    logic                       fre [N+1];
    logic [gmt_pkg::SLOT_W-1:0] fsl [N+1];
    logic [gmt_pkg::SLOT_W-1:0] esl [N+1];

    assign tok[0] = start;
    assign fnd[0] = 1'b0;
    assign fre[0] = 1'b0;
    assign fsl[0] = '0;
    assign esl[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        gmt_slot_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .my_slot      (gmt_pkg::SLOT_W'(i)),
            .write_en     (write_en && (sel_slot == gmt_pkg::SLOT_W'(i))),
            .clear_en     (clear_en && (sel_slot == gmt_pkg::SLOT_W'(i))),
            .write_gid    (key),
            .key          (key),
            .tok_in       (tok[i]),
            .fnd_in       (fnd[i]),
            .fnd_slot_in  (fsl[i]),
            .fre_in       (fre[i]),
            .fre_slot_in  (esl[i]),
            .tok_out      (tok[i+1]),
            .fnd_out      (fnd[i+1]),
            .fnd_slot_out (fsl[i+1]),
            .fre_out      (fre[i+1]),
            .fre_slot_out (esl[i+1])
        );
    end

    assign done           = tok[N];
    assign res.found      = fnd[N];
    assign res.found_slot = fsl[N];
    assign res.free       = fre[N];
    assign res.free_slot  = esl[N];

endmodule

// ----- rtl/core/group_membership_table_top.sv -----
// top level: command sequencer, member memory and slot chain
// Each command yields one item of status and is_member. The accepted command is
// registered, then a token walks the 16-cell slot chain. Member commands then read
// the group's list from the member memory entry by entry, a read and a compare (up
// to MEMBERS_PER_GROUP entries). Remove member moves each later entry down, a read
// and then a write, through the memory's separate read and write ports. One command
// is worked on at a time; the result sits in an output register and input stall stays
// high until it is taken.
module group_membership_table_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [31:0] group_id,
    input  logic [31:0] user_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        is_member,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    localparam int MPG = gmt_pkg::MEMBERS_PER_GROUP;

    gmt_pkg::state_t    state_reg, state_next;
    gmt_pkg::scan_res_t sres;
    logic               scan_done;

    logic [31:0] prot_reg;
    logic [2:0]  cmd_reg;
    logic [31:0] gid_reg, uid_reg;
    logic [gmt_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [gmt_pkg::COUNT_W-1:0] cnt_reg [gmt_pkg::GROUP_SLOTS];
    logic [gmt_pkg::COUNT_W-1:0] idx_reg, idx_next;
    logic [1:0]  status_reg, status_next;
    logic        member_reg, member_next;
    logic        out_valid_reg, out_valid_next;

    logic        start_reg;
    logic        g_wr, g_clr;
    logic        cnt_inc, cnt_dec, cnt_clr;

    logic [31:0] mem [gmt_pkg::DEPTH];
    logic [31:0] rdata_reg;
    logic        m_we;
    logic [31:0] m_wdata;
    logic [gmt_pkg::ADDR_W-1:0] m_waddr, m_raddr;
    logic        m_re;
    logic [gmt_pkg::COUNT_W-1:0] ncnt;

    assign ncnt = cnt_reg[slot_reg];

    gmt_slot_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .key      (gid_reg),
        .write_en (g_wr),
        .clear_en (g_clr),
        .sel_slot (slot_reg),
        .done     (scan_done),
        .res      (sres)
    );

    function automatic logic [gmt_pkg::ADDR_W-1:0] addr_of(
        input logic [gmt_pkg::SLOT_W-1:0]  s,
        input logic [gmt_pkg::COUNT_W-1:0] i
    );
        logic [gmt_pkg::ADDR_W+gmt_pkg::COUNT_W:0] a;
        a = ($bits(a))'(s) * ($bits(a))'(MPG) + ($bits(a))'(i);
        return a[gmt_pkg::ADDR_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (m_we)
            mem[m_waddr] <= m_wdata;
        if (m_re)
            rdata_reg <= mem[m_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gmt_pkg::S_IDLE;
            prot_reg      <= '0;
            out_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
            for (int i = 0; i < gmt_pkg::GROUP_SLOTS; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            // launch the token once the key register holds the new group
            start_reg     <= in_valid && !in_stall;
            if (cfg_we)
                prot_reg <= cfg_wdata;
            if (cnt_clr)
                cnt_reg[slot_reg] <= '0;
            else if (cnt_inc)
                cnt_reg[slot_reg] <= cnt_reg[slot_reg] + 1'b1;
            else if (cnt_dec)
                cnt_reg[slot_reg] <= cnt_reg[slot_reg] - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg <= command;
            gid_reg <= group_id;
            uid_reg <= user_id;
        end
        slot_reg   <= slot_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        member_reg <= member_next;
    end

    assign in_stall = (state_reg != gmt_pkg::S_IDLE) || out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        member_next    = member_reg;
        out_valid_next = out_valid_reg && out_stall;
        g_wr    = 1'b0;
        g_clr   = 1'b0;
        cnt_inc = 1'b0;
        cnt_dec = 1'b0;
        cnt_clr = 1'b0;
        m_we    = 1'b0;
        m_wdata = uid_reg;
        m_waddr = addr_of(slot_reg, idx_reg);
        m_raddr = addr_of(slot_reg, idx_reg);
        m_re    = 1'b0;
        unique case (state_reg)
            gmt_pkg::S_IDLE:
            begin
                if (in_valid && !in_stall)
                    state_next = gmt_pkg::S_GSCAN;
            end
            gmt_pkg::S_GSCAN:
            begin
                if (scan_done)
                begin
                    status_next = gmt_pkg::ST_REJECT;
                    member_next = 1'b0;
                    idx_next    = '0;
                    slot_next   = sres.found_slot;
                    state_next  = gmt_pkg::S_DONE;
                    unique case (cmd_reg)
                        gmt_pkg::CMD_ADD_GROUP:
                        begin
                            if (sres.found)
                                status_next = gmt_pkg::ST_REJECT;
                            else if (!sres.free)
                                status_next = gmt_pkg::ST_FULL;
                            else
                            begin
                                status_next = gmt_pkg::ST_OK;
                                slot_next   = sres.free_slot;
                                state_next  = gmt_pkg::S_SHIFT;
                            end
                        end
                        gmt_pkg::CMD_DEL_GROUP:
                        begin
                            if (gid_reg != prot_reg && sres.found)
                            begin
                                status_next = gmt_pkg::ST_OK;
                                state_next  = gmt_pkg::S_SHIFT;
                            end
                        end
                        gmt_pkg::CMD_ADD_MEMBER, gmt_pkg::CMD_DEL_MEMBER,
                        gmt_pkg::CMD_QUERY:
                        begin
                            if (sres.found)
                                state_next = gmt_pkg::S_MREAD;
                            else if (cmd_reg == gmt_pkg::CMD_QUERY)
                                status_next = gmt_pkg::ST_OK;
                        end
                        default:
                            status_next = gmt_pkg::ST_REJECT;
                    endcase
                end
            end
            gmt_pkg::S_MREAD:
            begin
                // end of list: member absent
                if (idx_reg >= ncnt)
                begin
                    state_next = gmt_pkg::S_DONE;
                    unique case (cmd_reg)
                        gmt_pkg::CMD_ADD_MEMBER:
                        begin
                            if (ncnt >= gmt_pkg::COUNT_W'(MPG))
                                status_next = gmt_pkg::ST_FULL;
                            else
                            begin
                                m_we        = 1'b1;
                                cnt_inc     = 1'b1;
                                status_next = gmt_pkg::ST_OK;
                            end
                        end
                        gmt_pkg::CMD_QUERY:
                            status_next = gmt_pkg::ST_OK;
                        default:
                            status_next = gmt_pkg::ST_REJECT;
                    endcase
                end
                else
                begin
                    m_re       = 1'b1;
                    state_next = gmt_pkg::S_MSCAN;
                end
            end
            gmt_pkg::S_MSCAN:
            begin
                if (rdata_reg == uid_reg)
                begin
                    status_next = gmt_pkg::ST_OK;
                    state_next  = gmt_pkg::S_DONE;
                    if (cmd_reg == gmt_pkg::CMD_QUERY)
                        member_next = 1'b1;
                    else if (cmd_reg == gmt_pkg::CMD_DEL_MEMBER)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = gmt_pkg::S_SHIFT;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = gmt_pkg::S_MREAD;
                end
            end
            gmt_pkg::S_SHIFT:
            begin
                // group add and remove finish here; remove member moves later entries down
                if (cmd_reg == gmt_pkg::CMD_ADD_GROUP)
                begin
                    g_wr       = 1'b1;
                    cnt_clr    = 1'b1;
                    state_next = gmt_pkg::S_DONE;
                end
                else if (cmd_reg == gmt_pkg::CMD_DEL_GROUP)
                begin
                    g_clr      = 1'b1;
                    cnt_clr    = 1'b1;
                    state_next = gmt_pkg::S_DONE;
                end
                else if (idx_reg >= ncnt)
                begin
                    cnt_dec    = 1'b1;
                    state_next = gmt_pkg::S_DONE;
                end
                else
                begin
                    // read entry idx, write it to idx-1 next cycle
                    m_re       = 1'b1;
                    state_next = gmt_pkg::S_SHIFT;
                    if (member_reg)
                    begin
                        m_re       = 1'b0;
                        m_we       = 1'b1;
                        m_wdata    = rdata_reg;
                        m_waddr    = addr_of(slot_reg, idx_reg - 1'b1);
                        idx_next   = idx_reg + 1'b1;
                        member_next = 1'b0;
                    end
                    else
                        member_next = 1'b1;
                end
            end
            gmt_pkg::S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next     = gmt_pkg::S_IDLE;
                end
            end
            default:
                state_next = gmt_pkg::S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign is_member = member_reg;

endmodule

// ----- dv/tb_group_membership_table_top.sv -----
// testbench: self-checking stimulus and prediction for the group membership table
module tb_group_membership_table_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [31:0] group_id;
    logic [31:0] user_id;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic        is_member;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    typedef struct packed {
        logic [1:0] status;
        logic       is_member;
    } outcome_t;

    // predictor state
    logic [31:0]      prot_gid;
    logic             grp_used [gmt_pkg::GROUP_SLOTS];
    logic [31:0]      grp_ident [gmt_pkg::GROUP_SLOTS];
    int               grp_size [gmt_pkg::GROUP_SLOTS];
    logic [31:0]      grp_users [gmt_pkg::GROUP_SLOTS][gmt_pkg::MEMBERS_PER_GROUP];
    outcome_t         pending_outcomes[$];
    int               mismatches = 0;
    int               idle_cycles;
    bit               no_idle;
    bit               timed_out;
    logic [31:0]      gid_pool [8];
    logic [31:0]      uid_pool [24];

    group_membership_table_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .group_id(group_id), .user_id(user_id),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .is_member(is_member),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int lookup_group(logic [31:0] gid);
        for (int s = 0; s < gmt_pkg::GROUP_SLOTS; s++)
            if (grp_used[s] && grp_ident[s] == gid)
                return s;
        return -1;
    endfunction

    function automatic int lookup_user(int s, logic [31:0] uid);
        for (int i = 0; i < grp_size[s]; i++)
            if (grp_users[s][i] == uid)
                return i;
        return -1;
    endfunction

    function automatic outcome_t apply_command(logic [2:0] cmd, logic [31:0] gid,
                                               logic [31:0] uid);
        outcome_t r;
        int s;
        int m;
        r.status = gmt_pkg::ST_REJECT;
        r.is_member = 1'b0;
        unique case (cmd)
            gmt_pkg::CMD_ADD_GROUP:
            begin
                if (lookup_group(gid) < 0)
                begin
                    r.status = gmt_pkg::ST_FULL;
                    for (s = 0; s < gmt_pkg::GROUP_SLOTS; s++)
                        if (!grp_used[s])
                        begin
                            grp_used[s] = 1'b1;
                            grp_ident[s] = gid;
                            grp_size[s] = 0;
                            r.status = gmt_pkg::ST_OK;
                            break;
                        end
                end
            end
            gmt_pkg::CMD_DEL_GROUP:
            begin
                s = lookup_group(gid);
                if (gid != prot_gid && s >= 0)
                begin
                    grp_used[s] = 1'b0;
                    grp_size[s] = 0;
                    r.status = gmt_pkg::ST_OK;
                end
            end
            gmt_pkg::CMD_ADD_MEMBER:
            begin
                s = lookup_group(gid);
                if (s >= 0)
                begin
                    if (lookup_user(s, uid) >= 0)
                        r.status = gmt_pkg::ST_OK;
                    else if (grp_size[s] >= gmt_pkg::MEMBERS_PER_GROUP)
                        r.status = gmt_pkg::ST_FULL;
                    else
                    begin
                        grp_users[s][grp_size[s]] = uid;
                        grp_size[s]++;
                        r.status = gmt_pkg::ST_OK;
                    end
                end
            end
            gmt_pkg::CMD_DEL_MEMBER:
            begin
                s = lookup_group(gid);
                m = (s >= 0) ? lookup_user(s, uid) : -1;
                if (m >= 0)
                begin
                    for (int j = m; j + 1 < grp_size[s]; j++)
                        grp_users[s][j] = grp_users[s][j + 1];
                    grp_size[s]--;
                    r.status = gmt_pkg::ST_OK;
                end
            end
            gmt_pkg::CMD_QUERY:
            begin
                r.status = gmt_pkg::ST_OK;
                s = lookup_group(gid);
                if (s >= 0 && lookup_user(s, uid) >= 0)
                    r.is_member = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_command(logic [2:0] cmd, logic [31:0] gid, logic [31:0] uid);
        while (!no_idle && $urandom_range(99) < 9)
            @(negedge clk);
        in_valid <= 1'b1;
        command  <= cmd;
        group_id <= gid;
        user_id  <= uid;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_outcomes.push_back(apply_command(cmd, gid, uid));
        @(negedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_protected(logic [31:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        prot_gid   = v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: status=%0d is_member=%0b", status, is_member);
            end
            else
            begin
                exp_o = pending_outcomes.pop_front();
                if (exp_o.status !== status || exp_o.is_member !== is_member)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status=%0d is_member=%0b, got %0d %0b",
                                 exp_o.status, exp_o.is_member, status, is_member);
                end
            end
        end
    end

    always @(negedge clk)
        out_stall <= !no_idle && ($urandom_range(99) < 9);

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("** group_membership_table_top: FAILED **");
            $finish;
        end
    end

    task automatic test_directed();
        send_command(gmt_pkg::CMD_QUERY, 32'h0, 32'h0);
        send_command(gmt_pkg::CMD_DEL_GROUP, 32'h0, 32'h0);            // protected, absent
        send_command(gmt_pkg::CMD_DEL_GROUP, 32'hFFFF_FFFF, 32'h0);    // unknown group
        send_command(gmt_pkg::CMD_ADD_MEMBER, 32'h5, 32'h1);           // unknown group
        send_command(gmt_pkg::CMD_DEL_MEMBER, 32'h5, 32'h1);
        send_command(gmt_pkg::CMD_ADD_GROUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(gmt_pkg::CMD_ADD_GROUP, 32'hFFFF_FFFF, 32'h0);    // duplicate group
        send_command(gmt_pkg::CMD_ADD_MEMBER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // duplicate member
        send_command(gmt_pkg::CMD_ADD_MEMBER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(gmt_pkg::CMD_ADD_MEMBER, 32'hFFFF_FFFF, 32'h0);
        send_command(gmt_pkg::CMD_QUERY, 32'hFFFF_FFFF, 32'h0);
        send_command(gmt_pkg::CMD_DEL_MEMBER, 32'hFFFF_FFFF, 32'h1234); // absent member
        send_command(gmt_pkg::CMD_DEL_MEMBER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(gmt_pkg::CMD_QUERY, 32'hFFFF_FFFF, 32'h0);
        send_command(3'd5, 32'h1, 32'h1);
        send_command(3'd6, 32'h1, 32'h1);
        send_command(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(gmt_pkg::CMD_DEL_GROUP, 32'hFFFF_FFFF, 32'h0);
    endtask

    task automatic test_full_lists();
        for (int g = 0; g < gmt_pkg::GROUP_SLOTS + 1; g++)
            send_command(gmt_pkg::CMD_ADD_GROUP, 32'h100 + g, 32'h0); // last finds table full
        for (int u = 0; u < gmt_pkg::MEMBERS_PER_GROUP + 1; u++)
            send_command(gmt_pkg::CMD_ADD_MEMBER, 32'h103, 32'h50 + u);
        send_command(gmt_pkg::CMD_DEL_MEMBER, 32'h103, 32'h50);        // shift the whole list
        send_command(gmt_pkg::CMD_QUERY, 32'h103, 32'h50 + gmt_pkg::MEMBERS_PER_GROUP - 1);
        send_command(gmt_pkg::CMD_ADD_MEMBER, 32'h103, 32'h50);
        write_protected(32'h105);
        send_command(gmt_pkg::CMD_DEL_GROUP, 32'h105, 32'h0);          // protected and present
        for (int g = 0; g < gmt_pkg::GROUP_SLOTS; g++)
            send_command(gmt_pkg::CMD_DEL_GROUP, 32'h100 + g, 32'h0);
    endtask

    task automatic test_random(int n);
        int c;
        logic [2:0] cmd;
        logic [31:0] gid;
        logic [31:0] uid;
        for (int i = 0; i < n; i++)
        begin
            no_idle = (i >= n / 2) && (i < n / 2 + 150);
            c = $urandom_range(99);
            if (c < 4)
                cmd = 3'($urandom_range(7, 5));
            else if (c < 16)
                cmd = gmt_pkg::CMD_ADD_GROUP;
            else if (c < 24)
                cmd = gmt_pkg::CMD_DEL_GROUP;
            else if (c < 56)
                cmd = gmt_pkg::CMD_ADD_MEMBER;
            else if (c < 74)
                cmd = gmt_pkg::CMD_DEL_MEMBER;
            else
                cmd = gmt_pkg::CMD_QUERY;
            gid = ($urandom_range(19) == 0) ? $urandom() : gid_pool[$urandom_range(7)];
            uid = ($urandom_range(19) == 0) ? $urandom() : uid_pool[$urandom_range(23)];
            send_command(cmd, gid, uid);
            if (i == n / 3)
                wait_drained();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = '0;
        group_id = '0;
        user_id = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        no_idle = 1'b0;
        prot_gid = '0;
        for (int s = 0; s < gmt_pkg::GROUP_SLOTS; s++)
        begin
            grp_used[s] = 1'b0;
            grp_size[s] = 0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_full_lists();
        for (int k = 0; k < 4; k++)
        begin
            for (int g = 0; g < 8; g++)
                gid_pool[g] = $urandom();
            gid_pool[0] = (k == 0) ? 32'h0 : 32'hFFFF_FFFF;
            for (int u = 0; u < 24; u++)
                uid_pool[u] = $urandom();
            uid_pool[0] = 32'h0;
            uid_pool[1] = 32'hFFFF_FFFF;
            case (k)
                0: write_protected(32'h0);
                1: write_protected(32'hFFFF_FFFF);
                2: write_protected(gid_pool[3]);
                default: write_protected($urandom());
            endcase
            test_random(355);
        end

        wait_drained();
        if (mismatches == 0)
            $display("** group_membership_table_top: PASSED **");
        else
            $display("** group_membership_table_top: FAILED **");
        $finish;
    end

endmodule
